// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every rising clock edge outside reset.
`define PAE_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define PAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pae_pkg.sv -----
`default_nettype none
package pae_pkg;

  localparam int unsigned DEF_CAPACITY = 32;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  // position, operand_value -> 38 bits, padded to 40
  localparam int unsigned IN_TDATA_W  = 40;
  // read_value, found, status, entry_count -> 41 bits, padded to 48
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LSEARCH = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_BSEARCH = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_GET     = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SET     = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_MAX     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef logic [VAL_W-1:0] word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pae_ram.sv -----
`default_nettype none
module pae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/positional_array_engine.sv -----
// Channel | Dir | Bits                                         | Handshake
// in_     | in  | tuser: opcode; tdata: position, operand_value | in_tvalid/in_tready
// out_    | out | tdata: read_value, found, status, entry_count | out_tvalid/out_tready
//
// One command at a time through a store with one write port and a registered read port;
// insert and delete shift the entries from the position onward one at a time, linear
// search and find-max read every entry, get reads one word and set writes one; sort then
// search runs an insertion sort, then a binary search that halves the range at each step.
// Synchronous active-low reset empties the array; stored words need no clearing.
// Input is taken only when idle; a finished result waits in the output register.
`default_nettype none
`include "assert_macros.svh"
module positional_array_engine #(
  parameter int unsigned CAPACITY = pae_pkg::DEF_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [5:0] position, [37:6] operand_value, [39:38] zero
  input  wire logic [pae_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] opcode
  input  wire logic [pae_pkg::OPCODE_W-1:0]    in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] read_value, [32] found, [34:33] status, [40:35] entry_count, [47:41] zero
  output logic      [pae_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pae_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_INS_RD = 4'd2;
  localparam logic [3:0] S_INS_WR = 4'd3;
  localparam logic [3:0] S_DEL_RD = 4'd4;
  localparam logic [3:0] S_DEL_WR = 4'd5;
  localparam logic [3:0] S_SC_RD  = 4'd6;
  localparam logic [3:0] S_SC_EX  = 4'd7;
  localparam logic [3:0] S_GET_EX = 4'd8;
  localparam logic [3:0] S_SO_LD  = 4'd9;
  localparam logic [3:0] S_SO_V   = 4'd10;
  localparam logic [3:0] S_SO_RD  = 4'd11;
  localparam logic [3:0] S_SO_CMP = 4'd12;
  localparam logic [3:0] S_BS_RD  = 4'd13;
  localparam logic [3:0] S_BS_CMP = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0]             state_r, state_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [OPCODE_W-1:0]    op_r, op_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  word_t                  val_r, val_nxt;
  word_t                  v_r, v_nxt;
  logic [LW-1:0]          idx_r, idx_nxt;
  logic [LW-1:0]          at_r, at_nxt;
  logic [LW-1:0]          outer_r, outer_nxt;
  logic [LW-1:0]          lo_r, lo_nxt;
  logic [LW-1:0]          hi_r, hi_nxt;
  logic [LW-1:0]          mid_r, mid_nxt;
  word_t                  rd_r, rd_nxt;
  logic                   fnd_r, fnd_nxt;
  logic [STATUS_W-1:0]    st_r, st_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  word_t                  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  word_t                  ram_rdata;

  logic [CW-1:0]          pos_c;
  logic [CW-1:0]          len_c;
  logic                   pos_ok;
  logic [LW-1:0]          idx_m1;
  logic [LW-1:0]          idx_p1;
  logic [LW-1:0]          mid_c;
  logic                   rd_gt_v;
  logic                   ins_end;
  logic                   done_load;

  pae_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pos_c   = CW'(pos_r);
  assign len_c   = CW'(len_r);
  assign pos_ok  = (pos_c < len_c);
  assign idx_m1  = idx_r - 1'b1;
  assign idx_p1  = idx_r + 1'b1;
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_gt_v = ($signed(ram_rdata) > $signed(v_r));

  assign ins_end   = (state_r == S_INS_RD) && (idx_r == at_r);
  assign done_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    at_nxt        = at_r;
    outer_nxt     = outer_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    rd_nxt        = rd_r;
    fnd_nxt       = fnd_r;
    st_nxt        = st_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          pos_nxt   = in_tdata[POS_W-1:0];
          val_nxt   = in_tdata[POS_W +: VAL_W];
          rd_nxt    = '0;
          fnd_nxt   = 1'b0;
          st_nxt    = ST_OK;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (len_r == CAP_L) begin
              st_nxt = ST_FULL;
            end else begin
              // a position at or past the end appends
              at_nxt    = pos_ok ? pos_c[LW-1:0] : len_r;
              idx_nxt   = len_r;
              state_nxt = S_INS_RD;
            end
          end
          OP_DELETE: begin
            if (len_r == '0) begin
              st_nxt = ST_EMPTY;
            end else if (!pos_ok) begin
              st_nxt = ST_RANGE;
            end else begin
              idx_nxt   = pos_c[LW-1:0];
              state_nxt = S_DEL_RD;
            end
          end
          OP_LSEARCH, OP_MAX: begin
            if (len_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SC_RD;
            end
          end
          OP_BSEARCH: begin
            if (len_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              outer_nxt = LW'(1);
              state_nxt = S_SO_LD;
            end
          end
          OP_GET: begin
            if (!pos_ok) begin
              st_nxt = ST_RANGE;
            end else begin
              ram_raddr = pos_c[AW-1:0];
              state_nxt = S_GET_EX;
            end
          end
          OP_SET: begin
            if (!pos_ok) begin
              st_nxt = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_c[AW-1:0];
              ram_wdata = val_r;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // shift entries up from the end down to the insert point
      S_INS_RD: begin
        if (idx_r == at_r) begin
          ram_we    = 1'b1;
          ram_waddr = at_r[AW-1:0];
          ram_wdata = val_r;
          len_nxt   = len_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = idx_m1[AW-1:0];
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_m1;
        state_nxt = S_INS_RD;
      end
      // pull later entries down over the removed one
      S_DEL_RD: begin
        if (idx_p1 < len_r) begin
          ram_raddr = idx_p1[AW-1:0];
          state_nxt = S_DEL_WR;
        end else begin
          len_nxt   = len_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_p1;
        state_nxt = S_DEL_RD;
      end
      S_SC_RD: begin
        if (idx_r < len_r) begin
          ram_raddr = idx_r[AW-1:0];
          state_nxt = S_SC_EX;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SC_EX: begin
        if (op_r == OP_LSEARCH) begin
          if (ram_rdata == val_r) begin
            fnd_nxt = 1'b1;
          end
        end else if ((idx_r == '0) || ($signed(ram_rdata) > $signed(rd_r))) begin
          rd_nxt = ram_rdata;
        end
        idx_nxt   = idx_p1;
        state_nxt = S_SC_RD;
      end
      S_GET_EX: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      // insertion sort: outer_r walks the entries, idx_r is the hole
      S_SO_LD: begin
        if (outer_r < len_r) begin
          ram_raddr = outer_r[AW-1:0];
          state_nxt = S_SO_V;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = len_r;
          state_nxt = S_BS_RD;
        end
      end
      S_SO_V: begin
        v_nxt     = ram_rdata;
        idx_nxt   = outer_r;
        state_nxt = S_SO_RD;
      end
      S_SO_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[AW-1:0];
          ram_wdata = v_r;
          outer_nxt = outer_r + 1'b1;
          state_nxt = S_SO_LD;
        end else begin
          ram_raddr = idx_m1[AW-1:0];
          state_nxt = S_SO_CMP;
        end
      end
      S_SO_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if (rd_gt_v) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
          state_nxt = S_SO_RD;
        end else begin
          ram_wdata = v_r;
          outer_nxt = outer_r + 1'b1;
          state_nxt = S_SO_LD;
        end
      end
      S_BS_RD: begin
        if (lo_r < hi_r) begin
          ram_raddr = mid_c[AW-1:0];
          mid_nxt   = mid_c;
          state_nxt = S_BS_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BS_CMP: begin
        if (ram_rdata == val_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if ($signed(ram_rdata) < $signed(val_r)) begin
            lo_nxt = mid_r + 1'b1;
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_BS_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUT_TDATA_W'({len_c[COUNT_W-1:0], st_r, fnd_r, rd_r});
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    v_r        <= v_nxt;
    idx_r      <= idx_nxt;
    at_r       <= at_nxt;
    outer_r    <= outer_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    rd_r       <= rd_nxt;
    fnd_r      <= fnd_nxt;
    st_r       <= st_nxt;
  end

  `PAE_ASSERT_HOLD(a_len_cap, len_r <= CAP_L, "length beyond capacity")
  `PAE_ASSERT_IMP(a_wr_range, ram_we, ram_waddr < CAPACITY, "store write out of range")
  `PAE_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `PAE_ASSERT_NEXT(a_ins_len, ins_end, len_r == $past(len_r) + 1'b1, "insert length")
  `PAE_ASSERT_NEXT(a_out_load, done_load, out_tvalid && in_tready, "result not loaded")

endmodule
`default_nettype wire

// ----- sim/positional_array_engine_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module positional_array_engine_tb;
  import pae_pkg::*;

  localparam int unsigned CAP = DEF_CAPACITY;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    position;
    word_t               operand_value;
  } array_cmd_t;

  typedef struct {
    word_t               read_value;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } array_reply_t;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED, PH_QUERY } phase_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OPCODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  array_cmd_t pending_cmds[$];
  array_reply_t expected_replies[$];
  array_cmd_t next_cmd;

  // shadow copy of the array
  logic signed [VAL_W-1:0] shadow_words [0:CAP-1];
  int unsigned shadow_len = 0;

  int error_count = 0;
  int issued_count = 0;
  int accepted_count = 0;
  int idle_level = 0;
  int send_wait = 0;
  int recv_stall = 0;
  int recv_draw = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  logic [OPCODE_W-1:0] all_ops [0:6] = '{OP_INSERT, OP_DELETE, OP_LSEARCH, OP_BSEARCH,
                                         OP_GET, OP_SET, OP_MAX};

  positional_array_engine #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_wait();
    case (idle_level)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  // apply one command to the shadow array and return the reply it should produce
  function automatic array_reply_t apply_command(logic [OPCODE_W-1:0] op,
                                                 logic [POS_W-1:0] pos, word_t val);
    array_reply_t r;
    int unsigned at, i, j, lo, hi, mid;
    logic signed [VAL_W-1:0] v, best;
    r.read_value = '0;
    r.found = 1'b0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          at = (pos < shadow_len) ? pos : shadow_len;
          for (i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_words[shadow_len-1] = '0;
          shadow_len--;
        end
      end
      OP_LSEARCH: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else
          for (i = 0; i < shadow_len; i++)
            if (shadow_words[i] == val) r.found = 1'b1;
      end
      OP_BSEARCH: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // insertion sort, signed ascending
          for (i = 1; i < shadow_len; i++) begin
            v = shadow_words[i];
            j = i;
            while (j > 0 && shadow_words[j-1] > v) begin
              shadow_words[j] = shadow_words[j-1];
              j--;
            end
            shadow_words[j] = v;
          end
          v = val;
          lo = 0;
          hi = shadow_len;
          while (lo < hi && !r.found) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_words[mid] == v) r.found = 1'b1;
            else if (shadow_words[mid] < v) lo = mid + 1;
            else hi = mid;
          end
        end
      end
      OP_GET: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_words[pos];
      end
      OP_SET: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else shadow_words[pos] = val;
      end
      OP_MAX: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = shadow_words[0];
          for (i = 1; i < shadow_len; i++)
            if (shadow_words[i] > best) best = shadow_words[i];
          r.read_value = best;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // drive commands
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          in_tuser <= next_cmd.opcode;
          in_tdata <= {2'b00, next_cmd.operand_value, next_cmd.position};
          in_tvalid <= 1'b1;
          send_wait <= draw_wait();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        recv_draw = draw_wait();
        recv_stall <= recv_draw;
        out_tready <= (recv_draw == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= (recv_stall == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // predict on accept, check on result
  always @(posedge clk) begin
    array_reply_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(apply_command(in_tuser, in_tdata[5:0], in_tdata[37:6]));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[31:0] !== want.read_value)
            report_mismatch($sformatf("read_value %h, want %h",
                                      out_tdata[31:0], want.read_value));
          if (out_tdata[32] !== want.found)
            report_mismatch($sformatf("found %b, want %b", out_tdata[32], want.found));
          if (out_tdata[34:33] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_tdata[34:33], want.status));
          if (out_tdata[40:35] !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      out_tdata[40:35], want.entry_count));
        end
      end
    end
  end

  task automatic queue_cmd(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos, word_t val);
    array_cmd_t c;
    c.opcode = op;
    c.position = pos;
    c.operand_value = val;
    pending_cmds.push_back(c);
    issued_count++;
  endtask

  function automatic logic [OPCODE_W-1:0] pick_opcode(phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL:  return (r < 80) ? OP_INSERT : all_ops[$urandom_range(1, 6)];
      PH_DRAIN: begin
        if (r < 60) return OP_DELETE;
        if (r < 70) return OP_INSERT;
        return all_ops[$urandom_range(2, 6)];
      end
      PH_QUERY: begin
        if (r < 10) return OP_INSERT;
        if (r < 15) return OP_DELETE;
        return all_ops[$urandom_range(2, 6)];
      end
      default:  return (r < 2) ? OP_UNUSED : all_ops[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return POS_W'($urandom_range(0, shadow_len));
    if (r < 85) return POS_W'($urandom_range(0, CAP));
    case ($urandom_range(0, 2))
      0: return (shadow_len > 0) ? POS_W'(shadow_len - 1) : '0;
      1: return POS_W'(CAP - 1);
      default: return POS_W'(CAP);
    endcase
  endfunction

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $signed($urandom_range(0, 6)) - 3;
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    // hit an existing entry so searches succeed often
    if (r < 65 && shadow_len > 0) return shadow_words[$urandom_range(0, shadow_len - 1)];
    return $urandom();
  endfunction

  initial begin
    int random_issued;
    int phase_len;
    phase_kind_t kind;
    random_issued = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty array corners
    queue_cmd(OP_DELETE, 0, 0);
    queue_cmd(OP_LSEARCH, 0, 5);
    queue_cmd(OP_BSEARCH, 0, 5);
    queue_cmd(OP_MAX, 0, 0);
    queue_cmd(OP_GET, 0, 0);
    queue_cmd(OP_SET, 0, 32'h1234_5678);
    queue_cmd(OP_UNUSED, 6'd63, 32'hffff_ffff);
    // append past the end, insert at front and middle
    queue_cmd(OP_INSERT, POS_W'(CAP), 32'h7fff_ffff);
    queue_cmd(OP_INSERT, 0, 32'h8000_0000);
    queue_cmd(OP_INSERT, 1, 32'hffff_ffff);
    queue_cmd(OP_INSERT, 5, 0);
    queue_cmd(OP_GET, 0, 0);
    queue_cmd(OP_GET, 3, 0);
    queue_cmd(OP_GET, 4, 0);
    queue_cmd(OP_SET, 1, 12345);
    queue_cmd(OP_LSEARCH, 0, 12345);
    queue_cmd(OP_LSEARCH, 0, 7);
    queue_cmd(OP_MAX, 0, 0);
    queue_cmd(OP_BSEARCH, 0, 32'h8000_0000);
    queue_cmd(OP_BSEARCH, 0, 99);
    queue_cmd(OP_DELETE, 4, 0);
    queue_cmd(OP_DELETE, 0, 0);
    queue_cmd(OP_DELETE, 2, 0);
    queue_cmd(OP_GET, POS_W'(CAP), 0);

    // random phases; the first one is mostly inserts, to fill the array toward capacity
    kind = PH_FILL;
    while (random_issued < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 160);
      idle_level = $urandom_range(0, 2);
      for (int n = 0; n < phase_len && random_issued < RANDOM_ITEMS; n++) begin
        wait (pending_cmds.size() < 3);
        queue_cmd(pick_opcode(kind), pick_position(), pick_value());
        random_issued++;
      end
      kind = phase_kind_t'($urandom_range(0, 3));
    end

    wait (accepted_count == issued_count && expected_replies.size() == 0);
    repeat (1200) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
